>>> sv/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg
// Types and constants shared by the cascaded prescaled timer block.
// ----------------------------------------------------------------------------
package cpt_pkg;

    localparam int TB_W       = 10;
    localparam int CNT_W      = 16;
    localparam int CTL_W      = 8;
    localparam int BUF_W      = 24;
    localparam int MAX_TIMERS = 8;
    localparam int IRQ_W      = 4;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam logic [BUF_W-1:0] MASK_T0 = 24'hC3FFFF;
    localparam logic [BUF_W-1:0] MASK_TN = 24'hC7FFFF;

    localparam int CTL_CASCADE = 2;
    localparam int CTL_IRQ_EN  = 6;
    localparam int CTL_ENABLE  = 7;

    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  reg_addr;
        logic [31:0] write_data;
        logic [31:0] write_mask;
    } in_item_t;

    typedef struct packed {
        logic [31:0]      read_data;
        logic [IRQ_W-1:0] irq_pulse;
    } out_item_t;

    // Low-bit mask of the time base for prescaler codes 0..3 (shift 0, 6, 8, 10)
    function automatic logic [TB_W-1:0] presc_mask(input logic [1:0] code);
        logic [TB_W-1:0] m;
        case (code)
            2'd0:    m = 10'h000;
            2'd1:    m = 10'h03F;
            2'd2:    m = 10'h0FF;
            default: m = 10'h3FF;
        endcase
        return m;
    endfunction

endpackage

>>> sv/cascaded_prescaled_timers.sv
// ----------------------------------------------------------------------------
// cascaded_prescaled_timers
// Cascaded 16-bit up-counting timers with a shared prescaled time base.
// ----------------------------------------------------------------------------
//  channel | signals                         | payload
//  --------+---------------------------------+-----------------------------
//  in      | in_valid / in_ready / in_item   | cmd, reg_addr, data, mask
//  out     | out_valid / out_ready / out_item| read_data, irq_pulse
//
//  One transaction per cycle unless the output stalls, through input and
//  result registers. All timer state updates in the same cycle the result
//  is registered, so the next transaction sees it. A stalled output holds
//  the input register; reset clears all timer state to zero.
// ----------------------------------------------------------------------------
module cascaded_prescaled_timers #(
    parameter int NUM_TIMERS = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cpt_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output cpt_pkg::out_item_t out_item
);
    import cpt_pkg::*;

    in_item_t  in_item_reg;
    logic      in_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic      out_valid_reg;
    logic      advance;

    logic [TB_W-1:0]  time_base_reg, time_base_next;
    logic [CNT_W-1:0] count_reg     [NUM_TIMERS];
    logic [CNT_W-1:0] count_next    [NUM_TIMERS];
    logic [CNT_W-1:0] reload_reg    [NUM_TIMERS];
    logic [CNT_W-1:0] reload_next   [NUM_TIMERS];
    logic [CTL_W-1:0] control_reg   [NUM_TIMERS];
    logic [CTL_W-1:0] control_next  [NUM_TIMERS];
    logic [BUF_W-1:0] buffered_reg  [NUM_TIMERS];
    logic [BUF_W-1:0] buffered_next [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] update_pending_reg, update_pending_next;
    logic [NUM_TIMERS-1:0] enable_pending_reg, enable_pending_next;
    logic [NUM_TIMERS-1:0] running_reg, running_next;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin : timer_logic
        logic                  carry;
        logic                  inc;
        logic                  old_en;
        logic                  new_en;
        logic [TB_W-1:0]       low;
        logic [1:0]            sel;
        logic                  sel_ok;
        logic [BUF_W-1:0]      wmask;
        logic [MAX_TIMERS-1:0] irq_all;
        logic [31:0]           rd;

        carry  = 1'b0;
        inc    = 1'b0;
        old_en = 1'b0;
        new_en = 1'b0;
        low    = '0;
        irq_all = '0;
        rd     = '0;
        sel    = in_item_reg.reg_addr[3:2];
        sel_ok = 32'(sel) < NUM_TIMERS;
        wmask  = in_item_reg.write_mask[BUF_W-1:0] & ((sel == 2'd0) ? MASK_T0 : MASK_TN);

        time_base_next      = time_base_reg;
        update_pending_next = update_pending_reg;
        enable_pending_next = enable_pending_reg;
        running_next        = running_reg;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            count_next[i]    = count_reg[i];
            reload_next[i]   = reload_reg[i];
            control_next[i]  = control_reg[i];
            buffered_next[i] = buffered_reg[i];
        end

        case (in_item_reg.cmd)
            CMD_TICK:
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (i > 0 && control_reg[i][CTL_CASCADE])
                    begin
                        inc = carry && running_reg[i];
                    end
                    else
                    begin
                        low = presc_mask(control_reg[i][1:0]);
                        inc = running_reg[i] && ((time_base_reg & low) == low);
                    end
                    carry = 1'b0;
                    if (inc)
                    begin
                        if (count_reg[i] == CNT_MAX)
                        begin
                            count_next[i] = reload_reg[i];
                            carry = 1'b1;
                            irq_all[i] = control_reg[i][CTL_IRQ_EN];
                        end
                        else
                        begin
                            count_next[i] = count_reg[i] + 16'd1;
                        end
                    end
                end
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (enable_pending_reg[i])
                    begin
                        enable_pending_next[i] = 1'b0;
                        running_next[i]        = 1'b1;
                        count_next[i]          = reload_reg[i];
                    end
                    if (update_pending_reg[i])
                    begin
                        old_en = control_reg[i][CTL_ENABLE];
                        new_en = buffered_reg[i][16 + CTL_ENABLE];
                        update_pending_next[i] = 1'b0;
                        reload_next[i]  = buffered_reg[i][CNT_W-1:0];
                        control_next[i] = buffered_reg[i][BUF_W-1:CNT_W];
                        if (!old_en && new_en)
                        begin
                            enable_pending_next[i] = 1'b1;
                        end
                        else if (old_en && !new_en)
                        begin
                            running_next[i] = 1'b0;
                        end
                    end
                end
                time_base_next = time_base_reg + 10'd1;
            end
            CMD_READ:
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (sel_ok && 32'(sel) == i)
                    begin
                        rd = {8'd0, control_reg[i], count_reg[i]};
                    end
                end
            end
            CMD_WRITE:
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (sel_ok && 32'(sel) == i)
                    begin
                        buffered_next[i] = (buffered_reg[i] & ~wmask)
                                         | (in_item_reg.write_data[BUF_W-1:0] & wmask);
                        update_pending_next[i] = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        out_item_next.read_data = rd;
        out_item_next.irq_pulse = irq_all[IRQ_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_base_reg      <= '0;
            update_pending_reg <= '0;
            enable_pending_reg <= '0;
            running_reg        <= '0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                count_reg[i]    <= '0;
                reload_reg[i]   <= '0;
                control_reg[i]  <= '0;
                buffered_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            time_base_reg      <= time_base_next;
            update_pending_reg <= update_pending_next;
            enable_pending_reg <= enable_pending_next;
            running_reg        <= running_next;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                count_reg[i]    <= count_next[i];
                reload_reg[i]   <= reload_next[i];
                control_reg[i]  <= control_next[i];
                buffered_reg[i] <= buffered_next[i];
            end
        end
    end

endmodule
